// ===== rtl/bblur_pkg.sv =====
`default_nettype none

package bblur_pkg;

  localparam int BBLUR_MAX_WIDTH  = 1024;
  localparam int BBLUR_MAX_HEIGHT = 1024;

  localparam int CFG_W   = 11;
  localparam int PIX_W   = 24;
  localparam int CHAN_W  = 8;
  localparam int SUM_W   = 12;   // nine 8-bit samples plus half of the count
  localparam int RECIP_W = 12;

  localparam logic [CFG_W-1:0] DEF_FRAME_WIDTH  = 11'd640;
  localparam logic [CFG_W-1:0] DEF_FRAME_HEIGHT = 11'd480;

  // configuration register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // neighborhood sizes that occur
  localparam logic [3:0] CNT_1 = 4'd1;
  localparam logic [3:0] CNT_2 = 4'd2;
  localparam logic [3:0] CNT_3 = 4'd3;
  localparam logic [3:0] CNT_4 = 4'd4;
  localparam logic [3:0] CNT_6 = 4'd6;
  localparam logic [3:0] CNT_9 = 4'd9;

  // per-item position info carried with a pixel to the averaging stage
  typedef struct packed {
    logic emit;
    logic done;
    logic left;
    logic right;
    logic top;
    logic bot;
  } bblur_flags_t;

  typedef struct packed {
    logic [RECIP_W-1:0] k;
    logic [4:0]         s;
  } bblur_recip_t;

  // floor(m / cnt) == (m * k) >> s for every m below 3276
  function automatic bblur_recip_t bblur_recip(input logic [3:0] cnt);
    bblur_recip_t r;
    case (cnt)
      CNT_1:   r = '{k: 12'd1,    s: 5'd0};
      CNT_2:   r = '{k: 12'd1,    s: 5'd1};
      CNT_3:   r = '{k: 12'd2731, s: 5'd13};
      CNT_4:   r = '{k: 12'd1,    s: 5'd2};
      CNT_6:   r = '{k: 12'd2731, s: 5'd14};
      CNT_9:   r = '{k: 12'd1821, s: 5'd14};
      default: r = '{k: 12'd1,    s: 5'd0};
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bblur_ram.sv =====
`default_nettype none

module bblur_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  wire                                  clk,
  input  wire                                  we,
  input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire [WIDTH-1:0]                      wdata,
  input  wire                                  re,
  input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first: a read at the address being written returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/box_blur_3x3_edge_aware_top.sv =====
// Channel  Handshake            Payload
// in       in_valid/in_ready    func, red_in, green_in, blue_in
// out      out_valid/out_ready  red_out, green_out, blue_out, frame_done
// cfg      wr_en                wr_index, wr_data
//
// One item per clock sustained while the output is not stalled; a result is
// registered into the output register when the pixel stage holding the item that completes its neighborhood advances.
// The two line stores share one read-first RAM, read at acceptance and
// written when the pixel stage advances; a same-address collision is forwarded.
// Synchronous reset clears the pipeline, positions and window; the RAM is
// not cleared. A stalled output holds the pixel stage; input stays open while
// the output register is free or being drained.
`default_nettype none

module box_blur_3x3_edge_aware_top
  import bblur_pkg::*;
#(
  parameter int MAX_WIDTH  = BBLUR_MAX_WIDTH,
  parameter int MAX_HEIGHT = BBLUR_MAX_HEIGHT
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire               func,
  input  wire  [CHAN_W-1:0] red_in,
  input  wire  [CHAN_W-1:0] green_in,
  input  wire  [CHAN_W-1:0] blue_in,
  output logic              out_valid,
  input  wire               out_ready,
  output logic [CHAN_W-1:0] red_out,
  output logic [CHAN_W-1:0] green_out,
  output logic [CHAN_W-1:0] blue_out,
  output logic              frame_done,
  input  wire               wr_en,
  input  wire               wr_index,
  input  wire  [CFG_W-1:0]  wr_data
);

  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int ORW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int IRW   = $clog2(MAX_HEIGHT + 2);
  localparam int CMPW  = WW + 1;
  localparam int HCMPW = HW + 1;
  localparam int PRODW = SUM_W + RECIP_W;

  function automatic logic [WW-1:0] clamp_w(input logic [CFG_W-1:0] v);
    if (v == '0) begin
      return WW'(1);
    end else if (32'(v) > 32'(MAX_WIDTH)) begin
      return WW'(MAX_WIDTH);
    end else begin
      return WW'(v);
    end
  endfunction

  function automatic logic [HW-1:0] clamp_h(input logic [CFG_W-1:0] v);
    if (v == '0) begin
      return HW'(1);
    end else if (32'(v) > 32'(MAX_HEIGHT)) begin
      return HW'(MAX_HEIGHT);
    end else begin
      return HW'(v);
    end
  endfunction

  // configuration and positions
  logic [WW-1:0]  frame_width;
  logic [HW-1:0]  frame_height;
  logic [CW-1:0]  in_column;
  logic [IRW-1:0] in_row;
  logic [CW-1:0]  out_column;
  logic [ORW-1:0] out_row;

  // pixel stage
  logic             s1_valid;
  bblur_flags_t     s1_flags;
  logic [CW-1:0]    s1_column;
  logic [PIX_W-1:0] s1_pix;
  logic             byp;
  logic [2*PIX_W-1:0] byp_data;
  logic [2*PIX_W-1:0] ram_rdata;
  logic [2*PIX_W-1:0] line_eff;

  logic [PIX_W-1:0] win      [3][3];
  logic [PIX_W-1:0] win_next [3][3];

  logic in_fire;
  logic s1_advance;
  logic restart;
  bblur_flags_t flags_now;

  logic in_col_last;
  logic out_col_last;

  assign restart    = wr_en && (wr_index == REG_FRAME_WIDTH || wr_index == REG_FRAME_HEIGHT);
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;
  assign in_fire    = in_valid && in_ready;

  assign in_col_last  = (CMPW'(in_column) + CMPW'(1)) >= CMPW'(frame_width);
  assign out_col_last = (CMPW'(out_column) + CMPW'(1)) >= CMPW'(frame_width);

  always_comb begin
    flags_now.emit  = (in_row >= IRW'(2)) || (in_row == IRW'(1) && in_column != '0);
    flags_now.left  = out_column != '0;
    flags_now.right = !out_col_last;
    flags_now.top   = out_row != '0;
    flags_now.bot   = (HCMPW'(out_row) + HCMPW'(1)) < HCMPW'(frame_height);
    flags_now.done  = !flags_now.bot && !flags_now.right;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= clamp_w(DEF_FRAME_WIDTH);
      frame_height <= clamp_h(DEF_FRAME_HEIGHT);
      in_column    <= '0;
      in_row       <= '0;
      out_column   <= '0;
      out_row      <= '0;
      s1_valid     <= 1'b0;
      out_valid    <= 1'b0;
      byp          <= 1'b0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_FRAME_WIDTH:  frame_width  <= clamp_w(wr_data);
          REG_FRAME_HEIGHT: frame_height <= clamp_h(wr_data);
          default: ;
        endcase
      end

      if (restart) begin
        in_column  <= '0;
        in_row     <= '0;
        out_column <= '0;
        out_row    <= '0;
      end else if (in_fire) begin
        if (flags_now.emit && flags_now.done) begin
          in_column  <= '0;
          in_row     <= '0;
          out_column <= '0;
          out_row    <= '0;
        end else begin
          if (in_col_last) begin
            in_column <= '0;
            in_row    <= in_row + IRW'(1);
          end else begin
            in_column <= in_column + CW'(1);
          end
          if (flags_now.emit) begin
            if (out_col_last) begin
              out_column <= '0;
              out_row    <= out_row + ORW'(1);
            end else begin
              out_column <= out_column + CW'(1);
            end
          end
        end
      end

      if (in_fire) begin
        s1_valid <= 1'b1;
        byp      <= s1_advance && (s1_column == in_column);
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end

      if (s1_advance) begin
        out_valid <= s1_flags.emit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // line stores: upper half of the word is the row two above, lower half one above
  bblur_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk   (clk),
    .we    (s1_advance),
    .waddr (s1_column),
    .wdata ({line_eff[PIX_W-1:0], s1_pix}),
    .re    (in_fire),
    .raddr (in_column),
    .rdata (ram_rdata)
  );

  assign line_eff = byp ? byp_data : ram_rdata;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_next[0][r] = win[1][r];
      win_next[1][r] = win[2][r];
    end
    win_next[2][0] = line_eff[2*PIX_W-1:PIX_W];
    win_next[2][1] = line_eff[PIX_W-1:0];
    win_next[2][2] = s1_pix;
  end

  // neighborhood sums and rounded mean: floor((sum + cnt/2) / cnt)
  logic [SUM_W-1:0]  sum_ch  [3];
  logic [SUM_W-1:0]  num_ch  [3];
  logic [PRODW-1:0]  prod_ch [3];
  logic [CHAN_W-1:0] mean_ch [3];
  logic [1:0]        n_cols;
  logic [1:0]        n_rows;
  logic [3:0]        cnt;
  bblur_recip_t      recip;

  always_comb begin
    n_cols = 2'd1 + {1'b0, s1_flags.left} + {1'b0, s1_flags.right};
    n_rows = 2'd1 + {1'b0, s1_flags.top} + {1'b0, s1_flags.bot};
    cnt    = {2'b00, n_cols} * {2'b00, n_rows};
    recip  = bblur_recip(cnt);
    for (int ch = 0; ch < 3; ch++) begin
      sum_ch[ch] = '0;
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          if ((c != 0 || s1_flags.left) && (c != 2 || s1_flags.right) &&
              (r != 0 || s1_flags.top) && (r != 2 || s1_flags.bot)) begin
            sum_ch[ch] = sum_ch[ch] +
                         SUM_W'(win_next[c][r][(2-ch)*CHAN_W +: CHAN_W]);
          end
        end
      end
      num_ch[ch]  = sum_ch[ch] + SUM_W'(cnt[3:1]);
      prod_ch[ch] = PRODW'(num_ch[ch]) * PRODW'(recip.k);
      mean_ch[ch] = CHAN_W'(prod_ch[ch] >> recip.s);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_flags  <= flags_now;
      s1_column <= in_column;
      s1_pix    <= func ? '0 : {red_in, green_in, blue_in};
      byp_data  <= {line_eff[PIX_W-1:0], s1_pix};
    end
    if (s1_advance && s1_flags.emit) begin
      red_out    <= mean_ch[0];
      green_out  <= mean_ch[1];
      blue_out   <= mean_ch[2];
      frame_done <= s1_flags.done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          win[c][r] <= '0;
        end
      end
    end else if (s1_advance) begin
      win <= win_next;
    end
  end

`ifndef NO_ASSERTIONS
  ast_done_restart: assert property (@(posedge clk) disable iff (rst)
    (in_fire && flags_now.emit && flags_now.done) |=>
      (in_column == '0 && in_row == '0 && out_column == '0 && out_row == '0))
    else $error("positions not cleared after last pixel of frame");

  ast_col_range: assert property (@(posedge clk) disable iff (rst)
    (CMPW'(in_column) < CMPW'(frame_width)) && (CMPW'(out_column) < CMPW'(frame_width)))
    else $error("column position beyond frame width");

  ast_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_advance) |=> s1_valid)
    else $error("pixel stage lost an item while stalled");

  ast_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_advance && s1_flags.emit))
    else $error("result appeared without an emitting pixel");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_box_blur_3x3_edge_aware_top.sv =====
module tb_box_blur_3x3_edge_aware_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bblur_pkg::*;

  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned SMALL_ITEMS   = 200;
  localparam int unsigned WHOLE_FRAME   = 32'hFFFF_FFFF;
  // far enough into a clamped-width frame that a few results come out
  localparam int unsigned CLAMP_CUT     = BBLUR_MAX_WIDTH + 9;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              done;
  } blur_px_t;

  // Tracks the frame position, line stores and window, and queues the
  // blurred pixel, if any, that each accepted input should produce.
  class box_mean_checker;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [PIX_W-1:0] upper_row [BBLUR_MAX_WIDTH];
    logic [PIX_W-1:0] middle_row [BBLUR_MAX_WIDTH];
    logic [PIX_W-1:0] win [3][3];
    int unsigned      in_col, in_row, out_col, out_row;
    blur_px_t         blurred_q[$];
    int unsigned      errors;

    function new();
      width_reg  = DEF_FRAME_WIDTH;
      height_reg = DEF_FRAME_HEIGHT;
      foreach (upper_row[i]) begin
        upper_row[i]  = '0;
        middle_row[i] = '0;
      end
      errors = 0;
      restart();
    endfunction

    function void restart();
      foreach (win[i, j]) win[i][j] = '0;
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
    endfunction

    function int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
    endfunction

    function logic [CHAN_W-1:0] mean_half_up(int unsigned s, int unsigned c);
      return CHAN_W'((2 * s + c) / (2 * c));
    endfunction

    function int unsigned pending();
      return blurred_q.size();
    endfunction

    function void write_reg(logic idx, logic [CFG_W-1:0] val);
      if (idx == REG_FRAME_WIDTH) width_reg = val;
      else height_reg = val;
      restart();
    endfunction

    function void note_pixel(logic f, logic [PIX_W-1:0] rgb);
      int unsigned      w, h, rr, cc, cnt;
      int unsigned      sum [3];
      logic [PIX_W-1:0] px, up, md, s;
      bit               emit;
      blur_px_t         res;
      w  = clamp_dim(width_reg, BBLUR_MAX_WIDTH);
      h  = clamp_dim(height_reg, BBLUR_MAX_HEIGHT);
      px = (f == FUNC_PIXEL) ? rgb : '0;
      up = upper_row[in_col];
      md = middle_row[in_col];
      upper_row[in_col]  = md;
      middle_row[in_col] = px;
      for (int d = 0; d < 3; d++) begin
        win[0][d] = win[1][d];
        win[1][d] = win[2][d];
      end
      // newest column: two rows up, one row up, current row
      win[2][0] = up;
      win[2][1] = md;
      win[2][2] = px;
      emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      if (!emit) return;

      rr  = out_row;
      cc  = out_col;
      cnt = 0;
      sum = '{0, 0, 0};
      for (int dc = 0; dc < 3; dc++) begin
        if ((dc == 0 && cc == 0) || (dc == 2 && cc + 1 >= w)) continue;
        for (int dr = 0; dr < 3; dr++) begin
          if ((dr == 0 && rr == 0) || (dr == 2 && rr + 1 >= h)) continue;
          s = win[dc][dr];
          sum[0] += s[23:16];
          sum[1] += s[15:8];
          sum[2] += s[7:0];
          cnt++;
        end
      end
      res.red   = mean_half_up(sum[0], cnt);
      res.green = mean_half_up(sum[1], cnt);
      res.blue  = mean_half_up(sum[2], cnt);
      res.done  = (rr + 1 >= h) && (cc + 1 >= w);
      blurred_q.push_back(res);

      cc++;
      if (cc >= w) begin
        cc = 0;
        rr++;
      end
      out_col = cc;
      out_row = rr;
      // last pixel of the frame: positions wrap, the window is kept
      if (res.done) begin
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
      end
    endfunction

    function void check_pixel(blur_px_t got);
      blur_px_t want;
      if (blurred_q.size() == 0) begin
        $error("output transaction with nothing expected: %h", got);
        errors++;
        return;
      end
      want = blurred_q.pop_front();
      if (got.red != want.red) begin
        $error("red_out: expected %0d, got %0d", want.red, got.red);
        errors++;
      end
      if (got.green != want.green) begin
        $error("green_out: expected %0d, got %0d", want.green, got.green);
        errors++;
      end
      if (got.blue != want.blue) begin
        $error("blue_out: expected %0d, got %0d", want.blue, got.blue);
        errors++;
      end
      if (got.done != want.done) begin
        $error("frame_done: expected %0d, got %0d", want.done, got.done);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              func = FUNC_PIXEL;
  logic [CHAN_W-1:0] red_in = '0;
  logic [CHAN_W-1:0] green_in = '0;
  logic [CHAN_W-1:0] blue_in = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CHAN_W-1:0] red_out;
  logic [CHAN_W-1:0] green_out;
  logic [CHAN_W-1:0] blue_out;
  logic              frame_done;
  logic              wr_en = 1'b0;
  logic              wr_index = REG_FRAME_WIDTH;
  logic [CFG_W-1:0]  wr_data = '0;

  box_mean_checker   sb;
  logic [CFG_W-1:0]  cur_w = DEF_FRAME_WIDTH;
  logic [CFG_W-1:0]  cur_h = DEF_FRAME_HEIGHT;
  bit                tx_calm = 1'b0;
  bit                rx_calm = 1'b0;
  int unsigned       stall_left = 0;
  int unsigned       quiet_cycles = 0;

  box_blur_3x3_edge_aware_top i_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // sink pacing: mostly ready, short stalls, now and then a long one
  always @(posedge clk) begin : rx_pace
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rx_calm || roll < 75) begin
      out_ready <= 1'b1;
    end else if (roll < 95) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(10, 40);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (wr_en) sb.write_reg(wr_index, wr_data);
      if (in_valid && in_ready) sb.note_pixel(func, {red_in, green_in, blue_in});
      if (out_valid && out_ready) sb.check_pixel({red_out, green_out, blue_out, frame_done});
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic int unsigned pick_gap(bit calm);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 70) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [CHAN_W-1:0] rand_chan();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return CHAN_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_item(input logic f, input logic [PIX_W-1:0] rgb);
    int unsigned gap;
    gap = pick_gap(tx_calm);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    {red_in, green_in, blue_in} <= rgb;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_frame(input bit do_w, input logic [CFG_W-1:0] wv,
                           input bit do_h, input logic [CFG_W-1:0] hv);
    if (do_w) begin
      wr_en    <= 1'b1;
      wr_index <= REG_FRAME_WIDTH;
      wr_data  <= wv;
      @(posedge clk);
      cur_w = wv;
    end
    if (do_h) begin
      wr_en    <= 1'b1;
      wr_index <= REG_FRAME_HEIGHT;
      wr_data  <= hv;
      @(posedge clk);
      cur_h = hv;
    end
    wr_en <= 1'b0;
  endtask

  // One frame plus its drain ticks, optionally cut short. Noise puts drain
  // ticks inside the frame and colored pixels where drain ticks are due.
  task automatic run_frame(input int unsigned cut, input bit noisy,
                           output int unsigned sent);
    int unsigned w, h, total;
    logic        f;
    w     = sb.clamp_dim(cur_w, BBLUR_MAX_WIDTH);
    h     = sb.clamp_dim(cur_h, BBLUR_MAX_HEIGHT);
    total = w * h + w + 1;
    sent  = 0;
    while (sent < total && sent < cut) begin
      if (sent < w * h) f = (noisy && $urandom_range(0, 15) == 0) ? FUNC_DRAIN : FUNC_PIXEL;
      else f = (noisy && $urandom_range(0, 3) == 0) ? FUNC_PIXEL : FUNC_DRAIN;
      send_item(f, {rand_chan(), rand_chan(), rand_chan()});
      sent++;
    end
  endtask

  initial begin : stimulus
    int unsigned      small_items, sent, nfr, sel, cut;
    logic [CFG_W-1:0] wv, hv;
    sb = new();
    small_items = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // 3x3: corner, edge and center neighborhoods, extremes, both noise kinds
    set_frame(1'b1, 11'd3, 1'b1, 11'd3);
    send_item(FUNC_PIXEL, 24'hFFFFFF);
    send_item(FUNC_PIXEL, 24'h000000);
    send_item(FUNC_PIXEL, 24'hFF00FF);
    send_item(FUNC_PIXEL, 24'h00FF00);
    send_item(FUNC_DRAIN, 24'hFFFFFF);
    send_item(FUNC_PIXEL, 24'hFFFFFF);
    send_item(FUNC_PIXEL, 24'h010203);
    send_item(FUNC_PIXEL, 24'hFE807F);
    send_item(FUNC_PIXEL, 24'hFFFFFF);
    send_item(FUNC_DRAIN, 24'h000000);
    send_item(FUNC_PIXEL, 24'hFFFFFF);
    send_item(FUNC_DRAIN, 24'h000000);
    send_item(FUNC_DRAIN, 24'h000000);
    wait_idle();

    // single pixel frame, divisor of one
    set_frame(1'b1, 11'd1, 1'b1, 11'd1);
    send_item(FUNC_PIXEL, 24'hAA55FF);
    send_item(FUNC_DRAIN, 24'h000000);
    send_item(FUNC_DRAIN, 24'h000000);
    wait_idle();

    // one column: divisors of two and three
    set_frame(1'b0, 11'd1, 1'b1, 11'd3);
    send_item(FUNC_PIXEL, 24'hFFFFFF);
    send_item(FUNC_PIXEL, 24'h000001);
    send_item(FUNC_PIXEL, 24'h80FF00);
    send_item(FUNC_DRAIN, 24'h000000);
    send_item(FUNC_DRAIN, 24'h000000);
    wait_idle();

    // size extremes: a width above maximum clamps (frame cut once the first
    // results are out, the next write restarts it), zero acts as one
    set_frame(1'b1, 11'd2047, 1'b1, 11'd1);
    run_frame(CLAMP_CUT, 1'b1, sent);
    wait_idle();
    set_frame(1'b1, 11'd0, 1'b1, 11'd0);
    run_frame(WHOLE_FRAME, 1'b1, sent);
    wait_idle();

    while (small_items < SMALL_ITEMS) begin
      wv = CFG_W'($urandom_range(1, 12));
      hv = CFG_W'($urandom_range(1, 8));
      if ($urandom_range(0, 9) == 0) wv = '0;
      if ($urandom_range(0, 9) == 0) hv = '0;
      sel = $urandom_range(0, 5);
      set_frame(sel != 1, wv, sel != 0, hv);
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      nfr = $urandom_range(1, 3);
      for (int i = 0; i < nfr; i++) begin
        // a cut frame is abandoned; the next register write restarts it
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : WHOLE_FRAME;
        run_frame(cut, 1'b1, sent);
        small_items += sent;
        if (cut != WHOLE_FRAME) break;
      end
      wait_idle();
    end

    wait_idle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
